@@ rtl/scs_pkg.sv @@
// Package for the scan code set 1 decoder: scan code constants, register
// indexes, the shared structs and the two character lookup tables.
// No dependencies.
package scs_pkg;

   // Scan code constants
   localparam logic [7:0] SC_CAPS      = 8'h3A;
   localparam logic [7:0] SC_LSHIFT    = 8'h2A;
   localparam logic [7:0] SC_RSHIFT    = 8'h36;
   localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
   localparam logic [7:0] SC_UP        = 8'h48;
   localparam logic [7:0] SC_LEFT      = 8'h4B;
   localparam logic [7:0] SC_DOWN      = 8'h50;
   localparam logic [7:0] SC_RIGHT     = 8'h4D;

   // Character constants
   localparam logic [7:0] LOWER_A    = 8'd97;
   localparam logic [7:0] LOWER_Z    = 8'd122;
   localparam logic [7:0] CASE_DELTA = 8'd32;

   // Register file
   localparam int unsigned CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARROW_BASE = 8'd1;
   localparam logic [7:0]           ARROW_BASE_RST = 8'd128;

   // Arrow offsets from the base code
   localparam logic [1:0] ARROW_OFS_UP    = 2'd0;
   localparam logic [1:0] ARROW_OFS_LEFT  = 2'd1;
   localparam logic [1:0] ARROW_OFS_DOWN  = 2'd2;
   localparam logic [1:0] ARROW_OFS_RIGHT = 2'd3;

   // Modifier flags kept between words
   typedef struct packed {
      logic caps_lock;
      logic lshift_on;
      logic rshift_on;
   } scs_flags_type;

   // Configuration seen by the decoder
   typedef struct packed {
      logic       enable;
      logic [7:0] arrow_base;
   } scs_cfg_type;

   // Unshifted character for a make code, 0 where nothing is mapped.
   function automatic logic [7:0] base_map(input logic [6:0] sc);
      logic [7:0] ch;
      case (sc)
         7'h01: ch = 8'h1B;
         7'h02: ch = 8'h31;
         7'h03: ch = 8'h32;
         7'h04: ch = 8'h33;
         7'h05: ch = 8'h34;
         7'h06: ch = 8'h35;
         7'h07: ch = 8'h36;
         7'h08: ch = 8'h37;
         7'h09: ch = 8'h38;
         7'h0A: ch = 8'h39;
         7'h0B: ch = 8'h30;
         7'h0C: ch = 8'h2D;
         7'h0D: ch = 8'h3D;
         7'h0E: ch = 8'h08;
         7'h0F: ch = 8'h09;
         7'h10: ch = 8'h71;
         7'h11: ch = 8'h77;
         7'h12: ch = 8'h65;
         7'h13: ch = 8'h72;
         7'h14: ch = 8'h74;
         7'h15: ch = 8'h79;
         7'h16: ch = 8'h75;
         7'h17: ch = 8'h69;
         7'h18: ch = 8'h6F;
         7'h19: ch = 8'h70;
         7'h1A: ch = 8'h5B;
         7'h1B: ch = 8'h5D;
         7'h1C: ch = 8'h0A;
         7'h1E: ch = 8'h61;
         7'h1F: ch = 8'h73;
         7'h20: ch = 8'h64;
         7'h21: ch = 8'h66;
         7'h22: ch = 8'h67;
         7'h23: ch = 8'h68;
         7'h24: ch = 8'h6A;
         7'h25: ch = 8'h6B;
         7'h26: ch = 8'h6C;
         7'h27: ch = 8'h3B;
         7'h28: ch = 8'h27;
         7'h29: ch = 8'h60;
         7'h2B: ch = 8'h5C;
         7'h2C: ch = 8'h7A;
         7'h2D: ch = 8'h78;
         7'h2E: ch = 8'h63;
         7'h2F: ch = 8'h76;
         7'h30: ch = 8'h62;
         7'h31: ch = 8'h6E;
         7'h32: ch = 8'h6D;
         7'h33: ch = 8'h2C;
         7'h34: ch = 8'h2E;
         7'h35: ch = 8'h2F;
         7'h37: ch = 8'h2A;
         7'h39: ch = 8'h20;
         7'h4A: ch = 8'h2D;
         7'h4E: ch = 8'h2B;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Shifted form of a digit or punctuation character, 0 where none exists.
   function automatic logic [7:0] shifted_map(input logic [6:0] ch);
      logic [7:0] sh;
      case (ch)
         7'h27: sh = 8'h22;
         7'h2C: sh = 8'h3C;
         7'h2D: sh = 8'h5F;
         7'h2E: sh = 8'h3E;
         7'h2F: sh = 8'h3F;
         7'h30: sh = 8'h29;
         7'h31: sh = 8'h21;
         7'h32: sh = 8'h40;
         7'h33: sh = 8'h23;
         7'h34: sh = 8'h24;
         7'h35: sh = 8'h25;
         7'h36: sh = 8'h5E;
         7'h37: sh = 8'h26;
         7'h38: sh = 8'h2A;
         7'h39: sh = 8'h28;
         7'h3B: sh = 8'h3A;
         7'h3D: sh = 8'h2B;
         7'h5B: sh = 8'h7B;
         7'h5C: sh = 8'h7C;
         7'h5D: sh = 8'h7D;
         7'h60: sh = 8'h7E;
         default: sh = 8'h00;
      endcase
      return sh;
   endfunction

endpackage

@@ rtl/scs_req_if.sv @@
// Input channel carrying one scan code byte per word.
// Depends on nothing.
interface scs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink   (input valid, input scan_code, output ready);
endinterface

@@ rtl/scs_rsp_if.sv @@
// Result channel carrying the key code and the modifier status per word.
// Depends on nothing.
interface scs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_code;
   logic       shift_held;
   logic       caps_on;

   modport source (output valid, output key_code, output shift_held, output caps_on,
                   input ready);
   modport sink   (input valid, input key_code, input shift_held, input caps_on,
                   output ready);
endinterface

@@ rtl/scs_csr_if.sv @@
// Configuration write channel: register index and write data.
// Depends on scs_pkg for the index width.
interface scs_csr_if
   import scs_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/scs_decode.sv @@
// Combinational decode of one scan code: next modifier flags and key code.
// Depends on scs_pkg for constants, tables and the flag and config structs.
module scs_decode
   import scs_pkg::*;
(
   input  logic [7:0]    scan_code,
   input  scs_flags_type flags_cur,
   input  scs_cfg_type   cfg,
   output logic [7:0]    key_code,
   output scs_flags_type flags_nxt
);

   logic       shift;
   logic [7:0] ch;
   logic [7:0] sh;
   logic       is_lower;
   logic [7:0] make_key;

   // Table lookup for an ordinary make code
   assign shift    = flags_cur.lshift_on | flags_cur.rshift_on;
   assign ch       = base_map(scan_code[6:0]);
   assign sh       = shifted_map(ch[6:0]);
   assign is_lower = (ch >= LOWER_A) && (ch <= LOWER_Z);

   always_comb begin
      if ((flags_cur.caps_lock != shift) && is_lower) begin
         make_key = ch - CASE_DELTA;
      end else if (shift && (ch < LOWER_A) && (sh != 8'h00)) begin
         make_key = sh;
      end else begin
         make_key = ch;
      end
   end

   // Modifier handling, arrows and release codes
   always_comb begin
      flags_nxt = flags_cur;
      key_code  = 8'h00;
      if (cfg.enable) begin
         if (!scan_code[7]) begin
            case (scan_code)
               SC_CAPS:   flags_nxt.caps_lock = ~flags_cur.caps_lock;
               SC_LSHIFT: flags_nxt.lshift_on = 1'b1;
               SC_RSHIFT: flags_nxt.rshift_on = 1'b1;
               SC_UP:     key_code = cfg.arrow_base + {6'd0, ARROW_OFS_UP};
               SC_LEFT:   key_code = cfg.arrow_base + {6'd0, ARROW_OFS_LEFT};
               SC_DOWN:   key_code = cfg.arrow_base + {6'd0, ARROW_OFS_DOWN};
               SC_RIGHT:  key_code = cfg.arrow_base + {6'd0, ARROW_OFS_RIGHT};
               default:   key_code = make_key;
            endcase
         end else begin
            case (scan_code)
               SC_LSHIFT_UP: flags_nxt.lshift_on = 1'b0;
               SC_RSHIFT_UP: flags_nxt.rshift_on = 1'b0;
               default:      flags_nxt = flags_cur;
            endcase
         end
      end
   end

endmodule

@@ rtl/scancode_set1_to_ascii.sv @@
// Scan code set 1 to ASCII decoder, top level.
// An accepted word passes through the input register, then the result
// register; one word per cycle while the result channel does not stall.
// The modifier flags update as a word moves from the input register to the
// result register. Synchronous active-high reset clears both stages and the
// flags, and sets enable to 1 and the arrow base to 128.
module scancode_set1_to_ascii
   import scs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   scs_req_if.sink    req_chan,
   scs_rsp_if.source  rsp_chan,
   scs_csr_if.sink    csr_chan
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_code_ff;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_key_ff;
   logic          out_shift_ff;
   logic          out_caps_ff;
   scs_flags_type flags_ff, flags_in;
   scs_cfg_type   cfg_ff, cfg_in;
   logic          out_free;
   logic          advance;
   logic          accept;
   logic [7:0]    dec_key;

   // Handshake: each stage takes a new word when it is empty or drains
   assign out_free        = ~out_valid_ff | rsp_chan.ready;
   assign advance         = in_valid_ff & out_free;
   assign req_chan.ready  = ~in_valid_ff | out_free;
   assign accept          = req_chan.valid & req_chan.ready;
   assign csr_chan.ready  = 1'b1;

   assign in_valid_in  = accept | (in_valid_ff & ~out_free);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_chan.ready);

   // Decoder between the two registers
   scs_decode u_decode (
      .scan_code (in_code_ff),
      .flags_cur (flags_ff),
      .cfg       (cfg_ff),
      .key_code  (dec_key),
      .flags_nxt (flags_in)
   );

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_ENABLE:     cfg_in.enable     = csr_chan.data[0];
            CSR_ARROW_BASE: cfg_in.arrow_base = csr_chan.data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         flags_ff            <= '0;
         cfg_ff.enable       <= 1'b1;
         cfg_ff.arrow_base   <= ARROW_BASE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            flags_ff <= flags_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_code_ff <= req_chan.scan_code;
      end
      if (advance) begin
         out_key_ff   <= dec_key;
         out_shift_ff <= flags_in.lshift_on | flags_in.rshift_on;
         out_caps_ff  <= flags_in.caps_lock;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.key_code   = out_key_ff;
   assign rsp_chan.shift_held = out_shift_ff;
   assign rsp_chan.caps_on    = out_caps_ff;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the scan code set 1 decoder: a directed table
// followed by random typing sessions, all checked against a local predictor.
// Depends on scs_pkg, the three channel interfaces and the decoder top level.
module tb_top;
   import scs_pkg::*;

   localparam int          NUM_ROWS        = 30;
   localparam int          NUM_PHASES      = 8;
   localparam int          ENABLED_BUDGET  = 105;
   localparam int          DISABLED_BUDGET = 40;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          STALL_LIMIT     = 4000;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          MAX_REPORTS     = 10;
   localparam logic [7:0]  RELEASE_BIT     = 8'h80;

   // One key word as the decoder reports it.
   typedef struct packed {
      logic [7:0] key_code;
      logic       shift_held;
      logic       caps_on;
   } key_word_type;

   typedef enum logic {ROW_SCAN, ROW_CSR} row_kind_type;

   // A directed row: a scan code word, or a register write.
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   code;
      logic [7:0]   data;
      logic         typed;
      logic [7:0]   key;
      logic         shift;
      logic         caps;
   } stim_row_type;

   typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_type;

   logic clock;
   logic reset;

   scs_req_if req_bus ();
   scs_rsp_if rsp_bus ();
   scs_csr_if csr_bus ();

   scancode_set1_to_ascii u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Local copy of the character tables and of the decoder state.
   logic [7:0] make_char  [0:127];
   logic [7:0] shift_char [0:255];
   logic [7:0] mapped_codes [$];
   logic       kb_caps;
   logic       kb_lshift;
   logic       kb_rshift;
   logic       cfg_enable;
   logic [7:0] cfg_arrow_base;

   key_word_type expected_keys [$];
   key_word_type pending_word;
   bit         pending_typed;
   bit         gaps_on;
   int         burst_left;
   int         raw_sent;
   int         decoded_count;
   int         csr_writes;
   int         results_checked;
   int         fault_count;
   int         hold_requests;
   int         idle_cycles;

   // Directed words: extremes, every modifier, arrows and the disabled case.
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{ROW_SCAN, 8'h00,          8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, 8'h1E,          8'h00, 1'b1, 8'h61, 1'b0, 1'b0},
      '{ROW_SCAN, SC_UP,          8'h00, 1'b1, 8'h80, 1'b0, 1'b0},
      '{ROW_SCAN, SC_LEFT,        8'h00, 1'b1, 8'h81, 1'b0, 1'b0},
      '{ROW_SCAN, SC_DOWN,        8'h00, 1'b1, 8'h82, 1'b0, 1'b0},
      '{ROW_SCAN, SC_RIGHT,       8'h00, 1'b1, 8'h83, 1'b0, 1'b0},
      '{ROW_SCAN, 8'h7F,          8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, 8'h80,          8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, 8'hFF,          8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, SC_CAPS,        8'h00, 1'b1, 8'h00, 1'b0, 1'b1},
      '{ROW_SCAN, 8'h1E,          8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, 8'h0B,          8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, SC_LSHIFT,      8'h00, 1'b1, 8'h00, 1'b1, 1'b1},
      '{ROW_SCAN, 8'h1E,          8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, 8'h02,          8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, SC_CAPS,        8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, 8'h28,          8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, SC_RSHIFT,      8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, SC_LSHIFT_UP,   8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, 8'h2C,          8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, SC_RSHIFT_UP,   8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_CSR,  CSR_ENABLE,     8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, SC_CAPS,        8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, 8'h1E,          8'h00, 1'b1, 8'h00, 1'b0, 1'b0},
      '{ROW_CSR,  CSR_ENABLE,     8'h01, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_CSR,  CSR_ARROW_BASE, 8'hFC, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, SC_UP,          8'h00, 1'b1, 8'hFC, 1'b0, 1'b0},
      '{ROW_SCAN, SC_RIGHT,       8'h00, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{ROW_CSR,  CSR_ARROW_BASE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
      '{ROW_SCAN, SC_LEFT,        8'h00, 1'b1, 8'h01, 1'b0, 1'b0}
   };

   // Clock generation.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Places a run of characters into the make code table.
   task automatic fill_row(input int first, input string chars);
      for (int i = 0; i < chars.len(); i++) make_char[first + i] = chars[i];
   endtask

   // Builds the character tables and the pool of mapped make codes.
   initial begin : build_tables
      string pairs;
      for (int i = 0; i < 128; i++) make_char[i] = 8'h00;
      for (int i = 0; i < 256; i++) shift_char[i] = 8'h00;
      fill_row('h02, "1234567890-=");
      fill_row('h10, "qwertyuiop[]");
      fill_row('h1E, "asdfghjkl;'");
      fill_row('h2C, "zxcvbnm,./");
      make_char[8'h01] = 8'h1B;
      make_char[8'h0E] = 8'h08;
      make_char[8'h0F] = 8'h09;
      make_char[8'h1C] = 8'h0A;
      make_char[8'h29] = 8'h60;
      make_char[8'h2B] = 8'h5C;
      make_char[8'h37] = "*";
      make_char[8'h39] = " ";
      make_char[8'h4A] = "-";
      make_char[8'h4E] = "+";
      // Each pair is an unshifted character followed by its shifted form.
      pairs = "'\",<-_.>/?0)1!2@3#4$5%6^7&8*9(;:=+[{\\|]}";
      for (int i = 0; i + 1 < pairs.len(); i += 2) shift_char[pairs[i]] = pairs[i + 1];
      shift_char[8'h60] = 8'h7E;
      for (int i = 1; i < 128; i++)
         if (make_char[i] != 8'h00) mapped_codes.push_back(i[7:0]);
   end

   // Predicts the key word for one scan code and advances the local state.
   task automatic decode_scan(input logic [7:0] sc, output key_word_type w);
      logic [7:0] ch;
      logic [7:0] key;
      logic       shifted;
      key = 8'h00;
      if (cfg_enable) begin
         if (!sc[7]) begin
            case (sc)
               SC_CAPS:   kb_caps   = !kb_caps;
               SC_LSHIFT: kb_lshift = 1'b1;
               SC_RSHIFT: kb_rshift = 1'b1;
               SC_UP:     key = cfg_arrow_base + {6'd0, ARROW_OFS_UP};
               SC_LEFT:   key = cfg_arrow_base + {6'd0, ARROW_OFS_LEFT};
               SC_DOWN:   key = cfg_arrow_base + {6'd0, ARROW_OFS_DOWN};
               SC_RIGHT:  key = cfg_arrow_base + {6'd0, ARROW_OFS_RIGHT};
               default: begin
                  // Letters follow caps XOR shift; other characters only shift.
                  shifted = kb_lshift | kb_rshift;
                  ch      = make_char[sc[6:0]];
                  if ((kb_caps != shifted) && ch >= LOWER_A && ch <= LOWER_Z)
                     key = ch - CASE_DELTA;
                  else if (shifted && ch < LOWER_A && shift_char[ch] != 8'h00)
                     key = shift_char[ch];
                  else
                     key = ch;
               end
            endcase
         end else if (sc == SC_LSHIFT_UP) begin
            kb_lshift = 1'b0;
         end else if (sc == SC_RSHIFT_UP) begin
            kb_rshift = 1'b0;
         end
      end
      w.key_code   = key;
      w.shift_held = kb_lshift | kb_rshift;
      w.caps_on    = kb_caps;
   endtask

   // Offers one scan code word, inserting a random gap between bursts when gaps are on.
   task automatic send_scan(input logic [7:0] sc);
      int           gap;
      key_word_type w;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = gaps_on ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.scan_code <= sc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (cfg_enable) decoded_count++;
      decode_scan(sc, w);
      expected_keys.push_back(pending_typed ? pending_word : w);
      pending_typed = 1'b0;
      raw_sent++;
   endtask

   // Writes one register; valid stays high when another write follows.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value,
                            input bit keep_valid);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_ENABLE:     cfg_enable     = value[0];
         CSR_ARROW_BASE: cfg_arrow_base = value;
         default: ;
      endcase
      csr_writes++;
      if (!keep_valid) csr_bus.valid <= 1'b0;
   endtask

   // Stops offering and waits until every key word has come back.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_keys.size() != 0) @(posedge clock);
   endtask

   // A typed key: mostly mapped make codes, sometimes an arrow.
   function automatic logic [7:0] pick_key();
      logic [7:0] arrows [4];
      arrows = '{SC_UP, SC_LEFT, SC_DOWN, SC_RIGHT};
      if ($urandom_range(0, 7) == 0) return arrows[$urandom_range(0, 3)];
      return mapped_codes[$urandom_range(0, mapped_codes.size() - 1)];
   endfunction

   // One random stretch of keyboard traffic, well-formed most of the time.
   task automatic type_sequence();
      logic [7:0] shift_code;
      logic [7:0] key;
      bit         with_shift;
      int         n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            // A word typed key by key, with an optional shift held round it.
            shift_code = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
            with_shift = ($urandom_range(0, 2) == 0);
            if (with_shift) send_scan(shift_code);
            n = $urandom_range(1, 6);
            repeat (n) begin
               key = pick_key();
               send_scan(key);
               send_scan(key | RELEASE_BIT);
            end
            if (with_shift) send_scan(shift_code | RELEASE_BIT);
         end
         6: begin
            send_scan(SC_CAPS);
            send_scan(SC_CAPS | RELEASE_BIT);
         end
         7: begin
            n = $urandom_range(1, 4);
            repeat (n) send_scan(8'($urandom_range(0, 255)));
         end
         8: begin
            // Broken modifier sequences: stray presses and releases.
            case ($urandom_range(0, 3))
               0: send_scan(SC_LSHIFT);
               1: send_scan(SC_LSHIFT_UP);
               2: send_scan(SC_RSHIFT_UP);
               default: begin
                  send_scan(SC_RSHIFT);
                  send_scan(SC_LSHIFT);
                  send_scan(SC_LSHIFT_UP);
               end
            endcase
         end
         default: send_scan(8'($urandom_range(0, 127)));
      endcase
   endtask

   // Main stimulus: reset, directed table, then random phases.
   initial begin : stimulus
      stim_row_type row;
      bit           keep;
      logic         en;
      logic [7:0]   base;
      int           start;
      int           budget;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.scan_code <= 8'h00;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_ENABLE;
      csr_bus.data      <= 8'h00;
      kb_caps         = 1'b0;
      kb_lshift       = 1'b0;
      kb_rshift       = 1'b0;
      cfg_enable      = 1'b1;
      cfg_arrow_base  = ARROW_BASE_RST;
      pending_typed   = 1'b0;
      gaps_on         = 1'b1;
      burst_left      = 0;
      raw_sent        = 0;
      decoded_count   = 0;
      csr_writes      = 0;
      hold_requests   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table; register writes wait for the block to drain.
      for (int r = 0; r < NUM_ROWS; r++) begin
         row = directed_rows[r];
         if (row.kind == ROW_CSR) begin
            if (r == 0 || directed_rows[r - 1].kind != ROW_CSR) wait_idle();
            keep = (r + 1 < NUM_ROWS) && (directed_rows[r + 1].kind == ROW_CSR);
            csr_write(row.code, row.data, keep);
         end else begin
            pending_typed = row.typed;
            pending_word  = {row.key, row.shift, row.caps};
            send_scan(row.code);
         end
      end

      // Random phases, each under its own register setting.
      for (int p = 0; p < NUM_PHASES; p++) begin
         en      = !(p == 2 || p == 5);
         base    = (p == 0) ? 8'd0 : (p == 1) ? 8'd252 : 8'($urandom_range(0, 252));
         gaps_on = (p != 3 && p != 4);
         wait_idle();
         csr_write(CSR_ENABLE, {7'b0, en}, 1'b1);
         csr_write(CSR_ARROW_BASE, base, 1'b0);
         // Ask the receiver for a long hold-off while words keep coming.
         if (p == 3) hold_requests++;
         budget = en ? ENABLED_BUDGET : DISABLED_BUDGET;
         start  = raw_sent;
         while (raw_sent - start < budget) type_sequence();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d decoded and %0d ignored scan code words over %0d register writes;",
               decoded_count, raw_sent - decoded_count, csr_writes);
      $display("%0d key words checked, including a %0d-cycle output hold-off.",
               results_checked, HOLD_OFF_CYCLES);
      if (fault_count == 0 && expected_keys.size() == 0)
         $display("scancode_set1_to_ascii test passed");
      else
         $display("scancode_set1_to_ascii test failed");
      $finish;
   end

   // Receiver: changes its stall pattern now and then, and serves hold-offs.
   initial begin : receiver
      int          hold_left;
      int          mode_left;
      int          rx_cycle;
      int          hold_served;
      rx_mode_type stall_mode;
      hold_left   = 0;
      mode_left   = 0;
      rx_cycle    = 0;
      hold_served = 0;
      stall_mode  = RX_FREE;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_mode)
               RX_FREE:   rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_bus.ready <= (rx_cycle % 3 != 0);
            endcase
         end
      end
   end

   // Result checker: each key word against the oldest expectation.
   initial begin
      results_checked = 0;
      fault_count     = 0;
   end

   always @(posedge clock) begin : check_results
      key_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_keys.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("%0t: unexpected key word: key %h shift %b caps %b", $time,
                        rsp_bus.key_code, rsp_bus.shift_held, rsp_bus.caps_on);
         end else begin
            want = expected_keys.pop_front();
            results_checked++;
            if (rsp_bus.key_code !== want.key_code || rsp_bus.shift_held !== want.shift_held
                || rsp_bus.caps_on !== want.caps_on) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("%0t: key word mismatch: expected key %h shift %b caps %b, got key %h shift %b caps %b",
                           $time, want.key_code, want.shift_held, want.caps_on,
                           rsp_bus.key_code, rsp_bus.shift_held, rsp_bus.caps_on);
            end
         end
      end
   end

   // Watchdog: ends the run when no channel has moved a word for too long.
   initial idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
            $display("scancode_set1_to_ascii test failed");
            $finish;
         end
      end
   end

endmodule
